/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

/* sv/mvi_pkg.sv */
// ----------------------------------------------------------------------------
// Mesh vertex indexer package
// Sizes, vertex type, merge result type and float compare functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mvi_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W       = 10;
   localparam int FACE_W      = 16;
   localparam logic [FACE_W-1:0] FACE_MAX = '1;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } vertex_type;

   typedef struct packed {
      logic [2:0]             added;
      logic                   full;
      logic [2:0][ADDR_W-1:0] idx;
      logic [CNT_W-1:0]       count;
   } merge_type;

   function automatic logic is_nan(logic [31:0] v);
      return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
   endfunction

   function automatic logic coord_eq(logic [31:0] a, logic [31:0] b);
      logic r;
      if (is_nan(a) || is_nan(b)) begin
         r = 1'b0;
      end else if (((a | b) & 32'h7fff_ffff) == 32'd0) begin
         r = 1'b1;
      end else begin
         r = (a == b);
      end
      return r;
   endfunction

   function automatic logic vtx_eq(vertex_type a, vertex_type b);
      return coord_eq(a.x, b.x) && coord_eq(a.y, b.y) && coord_eq(a.z, b.z);
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(logic [ADDR_W-1:0] v);
      return IDX_W'(v);
   endfunction

endpackage

/* sv/mvi_lane.sv */
// ----------------------------------------------------------------------------
// Mesh vertex indexer lane
// Holds one vertex and records the first table entry that matches it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvi_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  mvi_pkg::vertex_type        vtx_in,
   input  logic                       rd_vld,
   input  mvi_pkg::vertex_type        rd_data,
   input  logic [mvi_pkg::ADDR_W-1:0] rd_addr,
   output mvi_pkg::vertex_type        vtx,
   output logic                       hit,
   output logic [mvi_pkg::ADDR_W-1:0] hit_idx
);
   import mvi_pkg::*;

   vertex_type        vtx_ff;
   logic              hit_ff;
   logic              hit_in;
   logic [ADDR_W-1:0] idx_ff;
   logic [ADDR_W-1:0] idx_in;

   always_comb begin
      hit_in = hit_ff;
      idx_in = idx_ff;
      if (start) begin
         hit_in = 1'b0;
      end else if (rd_vld && !hit_ff && vtx_eq(vtx_ff, rd_data)) begin
         hit_in = 1'b1;
         idx_in = rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      idx_ff <= idx_in;
      if (start) begin
         vtx_ff <= vtx_in;
      end
   end

   assign vtx     = vtx_ff;
   assign hit     = hit_ff;
   assign hit_idx = idx_ff;

   `ASSERT_NEXT(a_hit_found, !start && rd_vld && vtx_eq(vtx_ff, rd_data), hit_ff, "lane missed a match")
   `ASSERT_NEXT(a_hit_keeps, !start && hit_ff, $stable(idx_ff), "lane match index moved")

endmodule

/* sv/mvi_merge.sv */
// ----------------------------------------------------------------------------
// Mesh vertex indexer merge
// Combines the lane matches into final indices and assigns new entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvi_merge (
   input  logic [2:0]                      hit,
   input  logic [2:0][mvi_pkg::ADDR_W-1:0] hit_idx,
   input  mvi_pkg::vertex_type [2:0]       vtx,
   input  logic [mvi_pkg::CNT_W-1:0]       count,
   output mvi_pkg::merge_type              res
);
   import mvi_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   logic [CNT_W-1:0] n;

   // A vertex that misses the table may still equal a vertex appended
   // earlier in the same triangle; the earliest such append wins.
   always_comb begin
      n   = count;
      res = '0;
      if (hit[0]) begin
         res.idx[0] = hit_idx[0];
      end else if (n < DEPTH_C) begin
         res.idx[0]   = ADDR_W'(n);
         res.added[0] = 1'b1;
         n            = n + CNT_W'(1);
      end else begin
         res.full = 1'b1;
      end
      if (hit[1]) begin
         res.idx[1] = hit_idx[1];
      end else if (res.added[0] && vtx_eq(vtx[1], vtx[0])) begin
         res.idx[1] = res.idx[0];
      end else if (n < DEPTH_C) begin
         res.idx[1]   = ADDR_W'(n);
         res.added[1] = 1'b1;
         n            = n + CNT_W'(1);
      end else begin
         res.full = 1'b1;
      end
      if (hit[2]) begin
         res.idx[2] = hit_idx[2];
      end else if (res.added[0] && vtx_eq(vtx[2], vtx[0])) begin
         res.idx[2] = res.idx[0];
      end else if (res.added[1] && vtx_eq(vtx[2], vtx[1])) begin
         res.idx[2] = res.idx[1];
      end else if (n < DEPTH_C) begin
         res.idx[2]   = ADDR_W'(n);
         res.added[2] = 1'b1;
         n            = n + CNT_W'(1);
      end else begin
         res.full = 1'b1;
      end
      res.count = n;
   end

endmodule

/* sv/mesh_vertex_indexer.sv */
// After a triangle request is accepted, the single read port of the vertex
// memory sweeps the N entries already in the table (N at most 1024) once,
// one per cycle, while three lanes compare all three vertices against each
// entry; the scan is followed by a merge state, a write state that steps
// through the three vertices and writes each one that is new, and a result
// state. A new request is taken while a finished result still waits on the
// result channel.
// ----------------------------------------------------------------------------
// Mesh vertex indexer
// Deduplicates triangle vertices into an indexed table and numbers faces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mesh_vertex_indexer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_clear,
   input  logic [31:0]               req_v1_x,
   input  logic [31:0]               req_v1_y,
   input  logic [31:0]               req_v1_z,
   input  logic [31:0]               req_v2_x,
   input  logic [31:0]               req_v2_y,
   input  logic [31:0]               req_v2_z,
   input  logic [31:0]               req_v3_x,
   input  logic [31:0]               req_v3_y,
   input  logic [31:0]               req_v3_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [mvi_pkg::IDX_W-1:0] rsp_index_one,
   output logic [mvi_pkg::IDX_W-1:0] rsp_index_two,
   output logic [mvi_pkg::IDX_W-1:0] rsp_index_three,
   output logic                      rsp_added_one,
   output logic                      rsp_added_two,
   output logic                      rsp_added_three,
   output logic                      rsp_degenerate,
   output logic [mvi_pkg::FACE_W-1:0] rsp_face_number,
   output logic                      rsp_table_full
);
   import mvi_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_MERGE = 5'b00100,
      S_WRITE = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [FACE_W-1:0] face_ff, face_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   vertex_type        rd_data_ff;
   merge_type         res_ff, res_in;
   logic [1:0]        wsel_ff, wsel_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0][IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [2:0]        rsp_added_ff, rsp_added_in;
   logic              rsp_degen_ff, rsp_degen_in;
   logic [FACE_W-1:0] rsp_face_ff, rsp_face_in;
   logic              rsp_full_ff, rsp_full_in;

   vertex_type        mem [TABLE_DEPTH];

   logic                   start;
   logic                   issue;
   logic                   wr_en;
   logic                   load;
   logic                   degen;
   logic [2:0][IDX_W-1:0]  idx_out;
   vertex_type [2:0]       req_vtx;
   vertex_type [2:0]       lane_vtx;
   logic [2:0]             lane_hit;
   logic [2:0][ADDR_W-1:0] lane_idx;
   merge_type              merged;

   assign req_vtx[0] = '{x: req_v1_x, y: req_v1_y, z: req_v1_z};
   assign req_vtx[1] = '{x: req_v2_x, y: req_v2_y, z: req_v2_z};
   assign req_vtx[2] = '{x: req_v3_x, y: req_v3_y, z: req_v3_z};

   assign req_ready = (state_ff == S_IDLE);
   assign start     = req_valid && req_ready;
   assign issue     = (state_ff == S_SCAN) && (addr_ff < count_ff);
   assign wr_en     = (state_ff == S_WRITE) && res_ff.added[wsel_ff];
   assign load      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   for (genvar k = 0; k < 3; k++) begin : g_lane
      mvi_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .start   (start),
         .vtx_in  (req_vtx[k]),
         .rd_vld  (rd_vld_ff),
         .rd_data (rd_data_ff),
         .rd_addr (rd_addr_ff),
         .vtx     (lane_vtx[k]),
         .hit     (lane_hit[k]),
         .hit_idx (lane_idx[k])
      );
      assign idx_out[k] = to_idx(res_ff.idx[k]);
   end

   mvi_merge u_merge (
      .hit     (lane_hit),
      .hit_idx (lane_idx),
      .vtx     (lane_vtx),
      .count   (count_ff),
      .res     (merged)
   );

   assign degen = (idx_out[0] == idx_out[1]) || (idx_out[1] == idx_out[2]) ||
                  (idx_out[2] == idx_out[0]);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      face_in      = face_ff;
      addr_in      = addr_ff;
      res_in       = res_ff;
      wsel_in      = wsel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_added_in = rsp_added_ff;
      rsp_degen_in = rsp_degen_ff;
      rsp_face_in  = rsp_face_ff;
      rsp_full_in  = rsp_full_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               addr_in  = '0;
               state_in = S_SCAN;
               if (req_clear) begin
                  count_in = '0;
                  face_in  = '0;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            res_in   = merged;
            count_in = merged.count;
            wsel_in  = '0;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            wsel_in = wsel_ff + 2'd1;
            if (wsel_ff == 2'd2) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_out;
               rsp_added_in = res_ff.added;
               rsp_degen_in = degen;
               rsp_full_in  = res_ff.full;
               rsp_face_in  = degen ? '0 : face_ff;
               if (!degen && (face_ff != FACE_MAX)) begin
                  face_in = face_ff + FACE_W'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         face_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         face_ff      <= face_in;
         rd_vld_ff    <= issue;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      rd_addr_ff   <= addr_ff[ADDR_W-1:0];
      res_ff       <= res_in;
      wsel_ff      <= wsel_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_added_ff <= rsp_added_in;
      rsp_degen_ff <= rsp_degen_in;
      rsp_face_ff  <= rsp_face_in;
      rsp_full_ff  <= rsp_full_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[res_ff.idx[wsel_ff]] <= lane_vtx[wsel_ff];
      end
      if (issue) begin
         rd_data_ff <= mem[addr_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index_one   = rsp_idx_ff[0];
   assign rsp_index_two   = rsp_idx_ff[1];
   assign rsp_index_three = rsp_idx_ff[2];
   assign rsp_added_one   = rsp_added_ff[0];
   assign rsp_added_two   = rsp_added_ff[1];
   assign rsp_added_three = rsp_added_ff[2];
   assign rsp_degenerate  = rsp_degen_ff;
   assign rsp_face_number = rsp_face_ff;
   assign rsp_table_full  = rsp_full_ff;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(TABLE_DEPTH), "vertex count past table depth")
   `ASSERT_NEXT(a_merge_growth, state_ff == S_MERGE, (count_ff >= $past(count_ff)) && (count_ff - $past(count_ff) <= CNT_W'(3)), "merge grew count by more than three")

endmodule

/* tb/sv/mvi_checker.sv */
// ----------------------------------------------------------------------------
// Mesh vertex indexer checker
// Watches the request and response channels, keeps its own vertex table and
// face counter, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mvi_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_clear,
   input  logic [31:0]                req_v1_x,
   input  logic [31:0]                req_v1_y,
   input  logic [31:0]                req_v1_z,
   input  logic [31:0]                req_v2_x,
   input  logic [31:0]                req_v2_y,
   input  logic [31:0]                req_v2_z,
   input  logic [31:0]                req_v3_x,
   input  logic [31:0]                req_v3_y,
   input  logic [31:0]                req_v3_z,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [mvi_pkg::IDX_W-1:0]  rsp_index_one,
   input  logic [mvi_pkg::IDX_W-1:0]  rsp_index_two,
   input  logic [mvi_pkg::IDX_W-1:0]  rsp_index_three,
   input  logic                       rsp_added_one,
   input  logic                       rsp_added_two,
   input  logic                       rsp_added_three,
   input  logic                       rsp_degenerate,
   input  logic [mvi_pkg::FACE_W-1:0] rsp_face_number,
   input  logic                       rsp_table_full,
   output int                         fail_count,
   output int                         pending,
   output int                         face_total,
   output int                         full_total
);
   import mvi_pkg::*;

   typedef struct packed {
      logic [2:0][IDX_W-1:0] idx;
      logic [2:0]            added;
      logic                  degen;
      logic [FACE_W-1:0]     face;
      logic                  full;
   } face_rec_type;

   logic [95:0]       known_vertices [TABLE_DEPTH];
   int                vertex_total;
   logic [FACE_W-1:0] next_face;
   face_rec_type      expected_faces [$];

   function automatic bit float_nan(logic [31:0] v);
      return v[30:23] == 8'hff && v[22:0] != 0;
   endfunction

   function automatic bit float_same(logic [31:0] a, logic [31:0] b);
      if (float_nan(a) || float_nan(b)) return 0;
      if (a[30:0] == 0 && b[30:0] == 0) return 1;
      return a == b;
   endfunction

   task automatic index_triangle(input logic clr, input logic [2:0][95:0] tri_v);
      face_rec_type r;
      int           hit;
      r = '0;
      if (clr) begin
         vertex_total = 0;
         next_face = 0;
      end
      for (int k = 0; k < 3; k++) begin
         hit = -1;
         for (int i = 0; i < vertex_total && hit < 0; i++)
            if (float_same(known_vertices[i][95:64], tri_v[k][95:64]) &&
                float_same(known_vertices[i][63:32], tri_v[k][63:32]) &&
                float_same(known_vertices[i][31:0], tri_v[k][31:0]))
               hit = i;
         if (hit >= 0) begin
            r.idx[k] = IDX_W'(hit);
         end else if (vertex_total >= TABLE_DEPTH) begin
            r.full = 1;
         end else begin
            known_vertices[vertex_total] = tri_v[k];
            r.idx[k] = IDX_W'(vertex_total);
            r.added[k] = 1;
            vertex_total++;
         end
      end
      r.degen = r.idx[0] == r.idx[1] || r.idx[1] == r.idx[2] || r.idx[0] == r.idx[2];
      if (!r.degen) begin
         r.face = next_face;
         if (next_face != FACE_MAX) next_face++;
      end
      expected_faces = {expected_faces, r};
   endtask

   always @(posedge clock) begin
      face_rec_type e, a;
      if (reset) begin
         vertex_total = 0;
         next_face = 0;
         expected_faces.delete();
         fail_count <= 0;
         face_total <= 0;
         full_total <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            a.idx = {rsp_index_three, rsp_index_two, rsp_index_one};
            a.added = {rsp_added_three, rsp_added_two, rsp_added_one};
            a.degen = rsp_degenerate;
            a.face = rsp_face_number;
            a.full = rsp_table_full;
            if (expected_faces.size() == 0) begin
               $display("%0t: unexpected response %h", $time, a);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_faces.pop_front();
               if (a != e) begin
                  $display("%0t: mismatch expected idx %h added %b degen %b face %0d full %b",
                           $time, e.idx, e.added, e.degen, e.face, e.full);
                  $display("%0t:          actual   idx %h added %b degen %b face %0d full %b",
                           $time, a.idx, a.added, a.degen, a.face, a.full);
                  fail_count <= fail_count + 1;
               end
               if (!e.degen) face_total <= face_total + 1;
               if (e.full) full_total <= full_total + 1;
            end
         end
         if (req_valid && req_ready)
            index_triangle(req_clear, {{req_v3_x, req_v3_y, req_v3_z},
                                       {req_v2_x, req_v2_y, req_v2_z},
                                       {req_v1_x, req_v1_y, req_v1_z}});
      end
      pending <= expected_faces.size();
   end
endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Mesh vertex indexer testbench
// Drives directed and random triangles with random gaps and stalls and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import mvi_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic               req_clear = 0;
   logic [2:0][95:0]   req_tri = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [IDX_W-1:0]   rsp_index_one, rsp_index_two, rsp_index_three;
   logic               rsp_added_one, rsp_added_two, rsp_added_three;
   logic               rsp_degenerate, rsp_table_full;
   logic [FACE_W-1:0]  rsp_face_number;
   int                 fail_count, pending, face_total, full_total;
   logic [95:0]        pool [16];
   int                 sent;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   mesh_vertex_indexer u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_clear,
      .req_v1_x(req_tri[0][95:64]), .req_v1_y(req_tri[0][63:32]), .req_v1_z(req_tri[0][31:0]),
      .req_v2_x(req_tri[1][95:64]), .req_v2_y(req_tri[1][63:32]), .req_v2_z(req_tri[1][31:0]),
      .req_v3_x(req_tri[2][95:64]), .req_v3_y(req_tri[2][63:32]), .req_v3_z(req_tri[2][31:0]),
      .rsp_valid, .rsp_ready, .rsp_index_one, .rsp_index_two, .rsp_index_three,
      .rsp_added_one, .rsp_added_two, .rsp_added_three, .rsp_degenerate,
      .rsp_face_number, .rsp_table_full);

   mvi_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_clear,
      .req_v1_x(req_tri[0][95:64]), .req_v1_y(req_tri[0][63:32]), .req_v1_z(req_tri[0][31:0]),
      .req_v2_x(req_tri[1][95:64]), .req_v2_y(req_tri[1][63:32]), .req_v2_z(req_tri[1][31:0]),
      .req_v3_x(req_tri[2][95:64]), .req_v3_y(req_tri[2][63:32]), .req_v3_z(req_tri[2][31:0]),
      .rsp_valid, .rsp_ready, .rsp_index_one, .rsp_index_two, .rsp_index_three,
      .rsp_added_one, .rsp_added_two, .rsp_added_three, .rsp_degenerate,
      .rsp_face_number, .rsp_table_full, .fail_count, .pending, .face_total, .full_total);

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   function automatic logic [31:0] odd_coord();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7fc0_0000;
         3: return 32'hffff_ffff;
         4: return 32'h7f80_0000;
         5: return 32'h3f80_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [95:0] pick_vertex(int mode);
      logic [95:0] v;
      if (mode == 0) return {$urandom, $urandom, $urandom};
      if (mode == 1) return {odd_coord(), odd_coord(), odd_coord()};
      v = pool[$urandom_range(0, 15)];
      // Flip the sign of zero coordinates at random so that +0 and -0 meet.
      for (int c = 0; c < 3; c++)
         if (v[c*32 +: 31] == 0 && $urandom_range(0, 1)) v[c*32 + 31] = ~v[c*32 + 31];
      return v;
   endfunction

   task automatic send_triangle(input logic clr, input logic [2:0][95:0] t);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_clear <= clr;
      req_tri   <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_mixed(input logic clr);
      logic [2:0][95:0] t;
      for (int k = 0; k < 3; k++) t[k] = pick_vertex($urandom_range(0, 5) < 3 ? 2 : $urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) t[$urandom_range(0, 2)] = t[$urandom_range(0, 2)];
      send_triangle(clr, t);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 15) == 0) ? 0 : ($urandom_range(0, 3) != 0);
   end

   initial begin
      #4_000_000;
      $display("FAIL mesh_vertex_indexer");
      $finish;
   end

   initial begin
      sent = 0;
      for (int i = 0; i < 16; i++) pool[i] = {odd_coord(), odd_coord(), odd_coord()};
      pool[0] = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_triangle(0, {96'h0, {32'h8000_0000, 32'h8000_0000, 32'h0}, {32'h0, 32'h0, 32'h0}});
      send_triangle(0, {{3{32'h7fc0_0000}}, {3{32'h7fc0_0000}}, {3{32'hffff_ffff}}});
      send_triangle(0, {{3{32'hffff_ffff}}, {3{32'h7f80_0000}}, {3{32'hff80_0000}}});
      send_triangle(0, {{3{32'h3f80_0000}}, {3{32'h4000_0000}}, {3{32'h4040_0000}}});
      send_triangle(0, {{3{32'h3f80_0000}}, {3{32'h4000_0000}}, {3{32'h4040_0000}}});
      send_triangle(0, {{3{32'h4040_0000}}, {3{32'h3f80_0000}}, {3{32'h4080_0000}}});
      send_triangle(1, {{3{32'h0000_0001}}, {3{32'h8000_0001}}, {3{32'h7fff_ffff}}});
      send_triangle(0, {{32'h0, 32'h0, 32'h1}, {32'h0, 32'h1, 32'h0}, {32'h1, 32'h0, 32'h0}});

      for (int i = 0; i < 180; i++) begin
         if (i % 40 == 0)
            for (int p = 1; p < 16; p++) pool[p] = {odd_coord(), odd_coord(), $urandom};
         send_mixed(i % 40 == 0 || $urandom_range(0, 63) == 0);
      end
      send_triangle(0, {96'hffff_ffff_ffff_ffff_ffff_ffff, 96'h0, 96'h1});
      req_valid <= 0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Sent %0d triangles with random gaps and response stalls: %0d faces numbered,",
               sent, face_total);
      $display("%0d triangles met a full table.", full_total);
      if (fail_count == 0) begin
         $display("PASS mesh_vertex_indexer");
      end else begin
         $display("FAIL mesh_vertex_indexer");
      end
      $finish;
   end
endmodule
